>>> design/assert_macros.svh
// Assertion macros shared by the sparse matrix-vector accumulate RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error(msg);

// Expression must never be true on a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error(msg);

`endif

>>> design/smva_pkg.sv
// Types and constants shared by the sparse matrix-vector accumulate block.
package smva_pkg;

	// Vector store geometry and row counter width.
	localparam int VECTOR_DEPTH   = 4096;
	localparam int VEC_ADDR_W     = $clog2(VECTOR_DEPTH);
	localparam int ROW_COUNT_BITS = 16;

	// Field widths.
	localparam int OP_W         = 2;
	localparam int INDEX_W      = 12;
	localparam int VALUE_W      = 32;
	localparam int ROW_NUMBER_W = 16;
	localparam int SUM_W        = 64;

	// Output queue; credits cover the results still inside the pipeline.
	localparam int OUT_FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W     = $clog2(OUT_FIFO_DEPTH);
	localparam int FIFO_CNT_W     = $clog2(OUT_FIFO_DEPTH + 1);
	localparam int OCC_W          = $clog2(OUT_FIFO_DEPTH + 3);

	// Saturation limits of a signed Q32.32 sum.
	localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// Item operation codes.
	typedef enum logic [OP_W-1:0] {
		OP_LOAD    = 2'd0,
		OP_NONZERO = 2'd1,
		OP_ROW_END = 2'd2
	} op_t;

	// Control carried down the pipeline.
	typedef struct packed {
		logic valid;
		op_t  op;
	} stage_t;

	// One finished row.
	typedef struct packed {
		logic [ROW_NUMBER_W-1:0] row_number;
		logic [SUM_W-1:0]        row_sum;
		logic                    saturated;
	} result_t;

endpackage

>>> design/smva_ram.sv
// Generic single-port synchronous RAM with registered read data.
module smva_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write or registered read, one access per cycle
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

>>> design/smva_mac.sv
// Multiply stage and saturating row accumulator with row counter.
module smva_mac (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  smva_pkg::stage_t                     ctl_s1,
	input  logic signed [smva_pkg::VALUE_W-1:0]  value_s1,
	input  logic signed [smva_pkg::VALUE_W-1:0]  xval,
	input  logic                                 in_range_s1,
	output logic                                 push,
	output smva_pkg::result_t                    res
);

	`include "assert_macros.svh"

	smva_pkg::stage_t                      ctl_s2;
	logic signed [smva_pkg::SUM_W-1:0]     prod_s2;
	logic signed [smva_pkg::VALUE_W-1:0]   x_eff;
	logic [smva_pkg::SUM_W-1:0]            sum_q;
	logic                                  ovf_q;
	logic [smva_pkg::ROW_COUNT_BITS-1:0]   row_q;
	logic [smva_pkg::SUM_W-1:0]            sum_add;
	logic [smva_pkg::SUM_W-1:0]            sum_next;
	logic                                  ovf;

	// Column beyond the store reads x as zero
	assign x_eff = in_range_s1 ? xval : '0;

	// Stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	// Exact Q32.32 product
	always_ff @(posedge clk) begin
		prod_s2 <= value_s1 * x_eff;
	end

	// Saturating add
	always_comb begin
		sum_add  = sum_q + prod_s2;
		ovf      = (sum_q[smva_pkg::SUM_W-1] == prod_s2[smva_pkg::SUM_W-1]) &&
		           (sum_add[smva_pkg::SUM_W-1] != sum_q[smva_pkg::SUM_W-1]);
		sum_next = sum_add;
		if (ovf) begin
			sum_next = sum_q[smva_pkg::SUM_W-1] ? smva_pkg::SUM_MIN : smva_pkg::SUM_MAX;
		end
	end

	// Row state: accumulate on nonzero, emit and clear on row end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			ovf_q <= 1'b0;
			row_q <= '0;
		end else if (ctl_s2.valid) begin
			case (ctl_s2.op)
				smva_pkg::OP_NONZERO: begin
					sum_q <= sum_next;
					ovf_q <= ovf_q | ovf;
				end
				smva_pkg::OP_ROW_END: begin
					sum_q <= '0;
					ovf_q <= 1'b0;
					row_q <= row_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Result of a row end, taken before the clear
	assign push           = ctl_s2.valid && (ctl_s2.op == smva_pkg::OP_ROW_END);
	assign res.row_number = smva_pkg::ROW_NUMBER_W'(row_q);
	assign res.row_sum    = sum_q;
	assign res.saturated  = ovf_q;

	`ASSERT_PROP(a_row_end_clears, clk, arst_n, push |=> (sum_q == '0 && !ovf_q), "row sum not cleared after row end")

endmodule

>>> design/smva_fifo.sv
// Small output queue of finished row results.
module smva_fifo (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  smva_pkg::result_t                   din,
	input  logic                                pop,
	output smva_pkg::result_t                   dout,
	output logic [smva_pkg::FIFO_CNT_W-1:0]     count
);

	`include "assert_macros.svh"

	smva_pkg::result_t                   buf_q [smva_pkg::OUT_FIFO_DEPTH];
	logic [smva_pkg::FIFO_PTR_W-1:0]     wr_q;
	logic [smva_pkg::FIFO_PTR_W-1:0]     rd_q;
	logic [smva_pkg::FIFO_CNT_W-1:0]     count_q;
	logic                                do_pop;

	assign do_pop = pop && (count_q != '0);

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= din;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == smva_pkg::FIFO_PTR_W'(smva_pkg::OUT_FIFO_DEPTH - 1)) ?
				        '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == smva_pkg::FIFO_PTR_W'(smva_pkg::OUT_FIFO_DEPTH - 1)) ?
				        '0 : rd_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign dout  = buf_q[rd_q];
	assign count = count_q;

	`ASSERT_NEVER(a_no_overflow, clk, arst_n, push && (count_q == smva_pkg::FIFO_CNT_W'(smva_pkg::OUT_FIFO_DEPTH)), "push into full result queue")

endmodule

>>> design/csr_sparse_matvec_accumulate.sv
// Sparse matrix-vector accumulate: vector store, multiply-accumulate and result queue.
//
// Input words (s_*): tuser holds the operation (load vector entry, nonzero,
// row end); tdata holds the index and the signed Q16.16 value. Loads write the
// 32-bit vector store; nonzeros read it at their column, multiply and add the
// product to a saturating Q32.32 row sum; a row end emits one output word.
// Output words (m_*): row number and row sum in tdata, saturation flag in tuser.
// Throughput is one input word per cycle while s_tready is high. A row end's
// result is valid once it has passed the vector store read register, the
// registered 32x32 multiply, and the accumulator and queue write.
// The result queue is four words deep; s_tready drops while the queue plus the
// row ends still in the pipeline would fill it, so a stalled receiver holds
// the input back once four results are queued or still in flight.
// Reset clears the pipeline, the row sum, the saturation flag, the row counter
// and the queue. The vector store is not cleared: reload it before use.
module csr_sparse_matvec_accumulate (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // index[11:0], value[43:12], zero[47:44]
	input  logic [1:0]  s_tuser,   // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // row_number[15:0], row_sum[79:16]
	output logic [0:0]  m_tuser    // saturated[0]
);

	`include "assert_macros.svh"

	logic                                      accept;
	smva_pkg::op_t                             op_in;
	logic [smva_pkg::INDEX_W-1:0]              index_in;
	logic signed [smva_pkg::VALUE_W-1:0]       value_in;
	logic                                      in_range;
	logic                                      ram_en;
	logic signed [smva_pkg::VALUE_W-1:0]       xval;
	smva_pkg::stage_t                          ctl_s1;
	logic signed [smva_pkg::VALUE_W-1:0]       value_s1;
	logic                                      in_range_s1;
	logic                                      push;
	smva_pkg::result_t                         res;
	smva_pkg::result_t                         dout;
	logic [smva_pkg::FIFO_CNT_W-1:0]           fifo_count;
	logic                                      row_end_s1;
	logic [smva_pkg::OCC_W-1:0]                occ;

	// Input unpacking
	assign op_in    = smva_pkg::op_t'(s_tuser);
	assign index_in = s_tdata[smva_pkg::INDEX_W-1:0];
	assign value_in = s_tdata[smva_pkg::INDEX_W +: smva_pkg::VALUE_W];
	assign in_range = 32'(index_in) < 32'(smva_pkg::VECTOR_DEPTH);
	assign accept   = s_tvalid && s_tready;

	// Credit check: queue entries plus row ends still in flight
	assign row_end_s1 = ctl_s1.valid && (ctl_s1.op == smva_pkg::OP_ROW_END);
	assign occ = smva_pkg::OCC_W'(fifo_count) + smva_pkg::OCC_W'(row_end_s1) +
	             smva_pkg::OCC_W'(push);
	assign s_tready = occ < smva_pkg::OCC_W'(smva_pkg::OUT_FIFO_DEPTH);

	// Vector store access: write on load, read on nonzero
	assign ram_en = accept && ((op_in == smva_pkg::OP_LOAD && in_range) ||
	                           op_in == smva_pkg::OP_NONZERO);

	smva_ram #(
		.WIDTH(smva_pkg::VALUE_W),
		.DEPTH(smva_pkg::VECTOR_DEPTH)
	) u_vec_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (op_in == smva_pkg::OP_LOAD),
		.addr  (smva_pkg::VEC_ADDR_W'(index_in)),
		.wdata (value_in),
		.rdata (xval)
	);

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= accept;
			ctl_s1.op    <= op_in;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		value_s1    <= value_in;
		in_range_s1 <= in_range;
	end

	smva_mac u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl_s1      (ctl_s1),
		.value_s1    (value_s1),
		.xval        (xval),
		.in_range_s1 (in_range_s1),
		.push        (push),
		.res         (res)
	);

	smva_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (res),
		.pop    (m_tready),
		.dout   (dout),
		.count  (fifo_count)
	);

	// Output packing
	assign m_tvalid = fifo_count != '0;
	assign m_tdata  = {dout.row_sum, dout.row_number};
	assign m_tuser  = dout.saturated;

	`ASSERT_NEVER(a_credit_bound, clk, arst_n, occ > smva_pkg::OCC_W'(smva_pkg::OUT_FIFO_DEPTH), "results in flight exceed queue depth")

endmodule

>>> tb/csr_sparse_matvec_accumulate_test.sv
// Self-checking testbench for the sparse matrix-vector accumulate block.
module csr_sparse_matvec_accumulate_test;
	import smva_pkg::*;

	// Operation code the block must ignore.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 1400;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic [0:0]  m_tuser;

	csr_sparse_matvec_accumulate dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// Predicted block state.
	logic [VALUE_W-1:0]      x_store [VECTOR_DEPTH];
	bit                      x_loaded [VECTOR_DEPTH];
	int                      loaded_cols [$];
	logic [SUM_W-1:0]        acc_sum = '0;
	logic                    acc_sat = 1'b0;
	logic [ROW_NUMBER_W-1:0] row_count = '0;

	// Row results still owed by the block, oldest first.
	result_t rows_due [$];
	int      failures = 0;

	// Sender pacing.
	int burst_left = 0;
	int idle_max   = 0;
	int words_sent = 0;

	// Receiver pacing.
	int ready_mode = 0;
	int ready_left = 0;
	int rx_cycle   = 0;

	// Advance the predicted state by one accepted word.
	task automatic update_row_sum(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
			input logic [VALUE_W-1:0] val);
		longint           xv;
		longint           prod_s;
		logic [SUM_W-1:0] prod;
		logic [SUM_W-1:0] total;
		result_t          r;
		case (op)
			OP_LOAD: begin
				x_store[idx] = val;
				if (!x_loaded[idx]) begin
					x_loaded[idx] = 1'b1;
					loaded_cols.insert(loaded_cols.size(), int'(idx));
				end
			end
			OP_NONZERO: begin
				xv     = longint'(signed'(x_store[idx]));
				prod_s = longint'(signed'(val)) * xv;
				prod   = prod_s;
				total  = acc_sum + prod;
				// same-sign operands with a sign flip: clamp
				if (acc_sum[SUM_W-1] == prod[SUM_W-1] && total[SUM_W-1] != acc_sum[SUM_W-1]) begin
					total   = acc_sum[SUM_W-1] ? SUM_MIN : SUM_MAX;
					acc_sat = 1'b1;
				end
				acc_sum = total;
			end
			OP_ROW_END: begin
				r.row_number = row_count;
				r.row_sum    = acc_sum;
				r.saturated  = acc_sat;
				rows_due.insert(rows_due.size(), r);
				acc_sum   = '0;
				acc_sat   = 1'b0;
				row_count = row_count + 1'b1;
			end
			default: ;
		endcase
	endtask

	// Send one word; called and returns at a falling edge.
	task automatic send_item(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
			input logic [VALUE_W-1:0] val);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = (idle_max > 0) ? $urandom_range(0, idle_max) : 0;
			if (gap > 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tdata  = {4'b0, val, idx};
		s_tuser  = op;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		update_row_sum(op, idx, val);
		words_sent++;
		@(negedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] rand_value();
		logic [VALUE_W-1:0] v;
		case ($urandom_range(0, 5))
			0: v = 32'h8000_0000;
			1: v = 32'h7FFF_FFFF;
			2: begin
				v = $urandom_range(0, 32'h3FFFF);
				if ($urandom_range(0, 1)) v = -v;
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic logic [INDEX_W-1:0] rand_col();
		return loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
	endfunction

	// Extremes of the fields, an empty row, the unused code, an overwrite.
	task automatic test_directed();
		idle_max = 0;
		send_item(OP_LOAD, 12'd0, 32'h8000_0000);
		send_item(OP_LOAD, 12'hFFF, 32'h7FFF_FFFF);
		send_item(OP_LOAD, 12'd1, 32'h0000_0000);
		send_item(OP_LOAD, 12'd2, 32'h0001_0000);
		send_item(OP_LOAD, 12'd3, 32'hFFFF_0000);
		send_item(OP_ROW_END, 12'hFFF, 32'hFFFF_FFFF);
		send_item(OP_NONZERO, 12'hFFF, 32'h7FFF_FFFF);
		send_item(OP_NONZERO, 12'd0, 32'h8000_0000);
		send_item(OP_NONZERO, 12'd1, 32'h1234_5678);
		send_item(OP_ROW_END, 12'd0, 32'h0);
		send_item(OP_NONZERO, 12'd2, 32'hFFFF_FFFF);
		send_item(OP_UNUSED, 12'hFFF, 32'hFFFF_FFFF);
		send_item(OP_NONZERO, 12'd3, 32'h0003_8000);
		send_item(OP_ROW_END, 12'd0, 32'h0);
		send_item(OP_LOAD, 12'd2, 32'hFFFF_FFFF);
		send_item(OP_NONZERO, 12'd2, 32'h8000_0000);
		send_item(OP_UNUSED, 12'd0, 32'h0);
		send_item(OP_ROW_END, 12'd0, 32'h0);
	endtask

	// Clamp at both ends; the flag holds and later adds start from the clamp.
	task automatic test_saturation();
		idle_max = 2;
		send_item(OP_LOAD, 12'd0, 32'h8000_0000);
		repeat (3) send_item(OP_NONZERO, 12'd0, 32'h8000_0000);
		send_item(OP_NONZERO, 12'd0, 32'h7FFF_FFFF);
		send_item(OP_ROW_END, 12'd0, 32'h0);
		repeat (3) send_item(OP_NONZERO, 12'd0, 32'h7FFF_FFFF);
		send_item(OP_NONZERO, 12'd0, 32'h8000_0000);
		send_item(OP_ROW_END, 12'd0, 32'h0);
		// row right after a clamped one starts clean
		send_item(OP_NONZERO, 12'd0, 32'h0001_0000);
		send_item(OP_ROW_END, 12'd0, 32'h0);
	endtask

	// Rows of random length over loaded columns, with loads and noise mixed in.
	task automatic test_random_rows();
		int                 start;
		int                 pick;
		int                 n;
		logic [INDEX_W-1:0] c;
		start = words_sent;
		while (words_sent - start < RANDOM_WORDS) begin
			if ($urandom_range(0, 7) == 0) idle_max = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				send_item(OP_LOAD, INDEX_W'($urandom), rand_value());
			end else if (pick < 14) begin
				send_item(OP_UNUSED, INDEX_W'($urandom), VALUE_W'($urandom));
			end else if (pick < 20) begin
				// heavy row driven toward a clamp
				c = INDEX_W'($urandom);
				send_item(OP_LOAD, c, $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
				repeat ($urandom_range(2, 8))
					send_item(OP_NONZERO, c, $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
				send_item(OP_ROW_END, INDEX_W'($urandom), VALUE_W'($urandom));
			end else begin
				n = $urandom_range(0, 12);
				repeat (n) send_item(OP_NONZERO, rand_col(), rand_value());
				send_item(OP_ROW_END, INDEX_W'($urandom), VALUE_W'($urandom));
			end
		end
	endtask

	// Receiver: stall pattern in stretches of random mode.
	always @(negedge clk) begin
		if (ready_left == 0) begin
			ready_mode = $urandom_range(0, 3);
			ready_left = $urandom_range(8, 80);
		end
		ready_left--;
		rx_cycle++;
		case (ready_mode)
			0: m_tready = 1'b1;
			1: m_tready = ($urandom_range(0, 3) != 0);
			2: m_tready = ($urandom_range(0, 3) == 0);
			default: m_tready = ((rx_cycle % 5) < 2);
		endcase
	end

	// Compare each output word with the oldest owed row.
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (rows_due.size() == 0) begin
				$display("%0t: unexpected word row=%0d sum=%h sat=%b", $time,
					m_tdata[15:0], m_tdata[79:16], m_tuser[0]);
				failures++;
			end else begin
				exp_r = rows_due.pop_front();
				if (m_tdata[15:0] !== exp_r.row_number) begin
					$display("%0t: row_number expected %0d actual %0d", $time,
						exp_r.row_number, m_tdata[15:0]);
					failures++;
				end
				if (m_tdata[79:16] !== exp_r.row_sum) begin
					$display("%0t: row %0d row_sum expected %h actual %h", $time,
						exp_r.row_number, exp_r.row_sum, m_tdata[79:16]);
					failures++;
				end
				if (m_tuser[0] !== exp_r.saturated) begin
					$display("%0t: row %0d saturated expected %b actual %b", $time,
						exp_r.row_number, exp_r.saturated, m_tuser[0]);
					failures++;
				end
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_saturation();
		test_random_rows();
		s_tvalid = 1'b0;
		while (rows_due.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (failures == 0 && rows_due.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#30_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
